// ----- rtl/mru_pkg.sv -----
// ----------------------------------------------------------------------------
// mru_pkg
// Shared types and constants for the MRU recency list: request and response
// payloads, command codes and the control word of one list cell.
// ----------------------------------------------------------------------------
`default_nettype none

package mru_pkg;

  // Fixed field widths of the request and response
  localparam int unsigned KEY_W = 64;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned CMD_W = 2;

  // Limit register range
  localparam logic [CNT_W-1:0] LIMIT_LOW  = CNT_W'(4);
  localparam logic [CNT_W-1:0] LIMIT_HIGH = CNT_W'(16);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  // What a cell loads at the next edge
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     sel;   // cell drives its key onto the shared read bus
  } cell_ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] entry_key;
    logic             hit;
    logic [IDX_W-1:0] hit_position;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
    logic             index_error;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/mru_cell.sv -----
// ----------------------------------------------------------------------------
// mru_cell
// One slot of the recency list. Holds a key, compares it against the request
// key and loads from its left or right neighbor when the row shifts, or the new key.
// ----------------------------------------------------------------------------
`default_nettype none

module mru_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  wire logic                clk_i,
  input  wire mru_pkg::cell_ctrl_t ctrl_i,
  input  wire logic                valid_i,
  input  wire logic [KEY_BITS-1:0] new_key_i,
  input  wire logic [KEY_BITS-1:0] left_key_i,
  input  wire logic [KEY_BITS-1:0] right_key_i,
  output logic      [KEY_BITS-1:0] key_o,
  output logic      [KEY_BITS-1:0] sel_key_o,
  output logic                     match_o
);
  import mru_pkg::*;

  logic [KEY_BITS-1:0] key_q, key_d;

  // next key from the shift control
  always_comb begin
    case (ctrl_i.op)
      CELL_FROM_LEFT:  key_d = left_key_i;
      CELL_FROM_RIGHT: key_d = right_key_i;
      CELL_LOAD:       key_d = new_key_i;
      default:         key_d = key_q;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o     = key_q;
  assign match_o   = valid_i && (key_q == new_key_i);
  assign sel_key_o = ctrl_i.sel ? key_q : '0;

endmodule

`default_nettype wire

// ----- rtl/mru_recency_list.sv -----
// ----------------------------------------------------------------------------
// mru_recency_list
// Move-to-front list of keys held in a row of cells, newest first.
// ----------------------------------------------------------------------------
// The block takes one request on every clock (busy never rises) and shows its
// response on rsp_o for exactly one cycle, the cycle after the request, with
// rsp_valid_o high; the receiver cannot stall and must take it then. All key
// compares and the shift control of the cell row are combinational, which sets
// the rate of one request per cycle. Stored keys need no clearing after
// reset: only positions below the entry count are ever read. Limit writes go
// through the cfg channel, which is ready in every cycle in which start is low.
// ----------------------------------------------------------------------------
`default_nettype none

module mru_recency_list #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned KEY_BITS    = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire mru_pkg::req_t                   req_i,
  output mru_pkg::rsp_t                        rsp_o,
  output logic                                 rsp_valid_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mru_pkg::CNT_W-1:0]       cfg_data_i
);
  import mru_pkg::*;

  localparam int unsigned NumCells = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
  localparam int unsigned PosW     = $clog2(NumCells);
  localparam logic [CNT_W-1:0] LimitHigh =
      (CNT_W'(NumCells) < LIMIT_HIGH) ? CNT_W'(NumCells) : LIMIT_HIGH;

  logic                accept;
  logic [KEY_BITS-1:0] key;
  logic [CNT_W-1:0]    idx_ext;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    limit_q, limit_d;
  logic [CNT_W-1:0]    sel_addr;
  logic                idx_err;
  logic                hit;
  logic [PosW-1:0]     hit_pos;
  logic                evict;
  logic [KEY_BITS-1:0] sel_key;
  rsp_t                rsp_d, rsp_q;
  logic                rsp_valid_q;

  cell_ctrl_t          ctrl     [NumCells];
  logic                valid    [NumCells];
  logic                match    [NumCells];
  logic [KEY_BITS-1:0] cell_key [NumCells];
  logic [KEY_BITS-1:0] cell_sel [NumCells];

  assign busy        = 1'b0;
  assign cfg_ready_o = !start;
  assign accept      = start && !busy;
  assign key         = req_i.key[KEY_BITS-1:0];
  assign idx_ext     = CNT_W'(req_i.index);
  assign idx_err     = idx_ext >= count_q;
  assign evict       = count_q >= limit_q;

  // shared read address: oldest entry on add, requested index otherwise
  assign sel_addr = (req_i.command == CMD_ADD) ? (count_q - CNT_W'(1)) : idx_ext;

  // per-cell occupancy
  always_comb begin
    for (int i = 0; i < NumCells; i++) begin
      valid[i] = CNT_W'(i) < count_q;
    end
  end

  // first matching cell
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = NumCells - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_pos = PosW'(i);
      end
    end
  end

  // OR of the selected cell's key
  always_comb begin
    sel_key = '0;
    for (int i = 0; i < NumCells; i++) begin
      sel_key = sel_key | cell_sel[i];
    end
  end

  // shift control of the row
  always_comb begin
    for (int i = 0; i < NumCells; i++) begin
      ctrl[i].sel = CNT_W'(i) == sel_addr;
      ctrl[i].op  = CELL_HOLD;
      if (accept) begin
        case (req_i.command)
          CMD_ADD: begin
            if (i == 0) begin
              ctrl[i].op = CELL_LOAD;
            end else if (!hit || CNT_W'(i) <= CNT_W'(hit_pos)) begin
              ctrl[i].op = CELL_FROM_LEFT;
            end
          end
          CMD_REMOVE: begin
            if (!idx_err && CNT_W'(i) >= idx_ext && i < NumCells - 1) begin
              ctrl[i].op = CELL_FROM_RIGHT;
            end
          end
          default: ctrl[i].op = CELL_HOLD;
        endcase
      end
    end
  end

  // cell row
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    logic [KEY_BITS-1:0] left_key, right_key;
    if (g == 0) begin : g_first
      assign left_key = key;
    end else begin : g_mid_left
      assign left_key = cell_key[g-1];
    end
    if (g == NumCells - 1) begin : g_last
      assign right_key = cell_key[g];
    end else begin : g_mid_right
      assign right_key = cell_key[g+1];
    end

    mru_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[g]),
      .valid_i     (valid[g]),
      .new_key_i   (key),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .key_o       (cell_key[g]),
      .sel_key_o   (cell_sel[g]),
      .match_o     (match[g])
    );
  end

  // response and next count
  always_comb begin
    rsp_d   = '0;
    count_d = count_q;
    case (req_i.command)
      CMD_ADD: begin
        if (hit) begin
          rsp_d.hit          = 1'b1;
          rsp_d.hit_position = IDX_W'(hit_pos);
        end else if (evict) begin
          rsp_d.evicted     = 1'b1;
          rsp_d.evicted_key = KEY_W'(sel_key);
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_READ: begin
        if (idx_err) begin
          rsp_d.index_error = 1'b1;
        end else begin
          rsp_d.entry_key = KEY_W'(sel_key);
        end
      end
      CMD_REMOVE: begin
        if (idx_err) begin
          rsp_d.index_error = 1'b1;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: count_d = count_q;
    endcase
    rsp_d.entry_count = count_d;
  end

  // clamped limit write
  always_comb begin
    if (cfg_data_i < LIMIT_LOW) begin
      limit_d = LIMIT_LOW;
    end else if (cfg_data_i > LimitHigh) begin
      limit_d = LimitHigh;
    end else begin
      limit_d = cfg_data_i;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= LimitHigh;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end else if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= limit_d;
        if (count_q > limit_d) begin
          count_q <= limit_d;
        end
      end
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

  // count stays within the limit
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= limit_q)
    else $error("entry count above limit");

  // a request gives a response on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> rsp_valid_o)
    else $error("missing response strobe");

  // a hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      rsp_valid_o |-> !(rsp_o.hit && rsp_o.evicted))
    else $error("hit and eviction together");

  // an add of a new key with room grows the list by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept && req_i.command == CMD_ADD && !hit && !evict)
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list");

endmodule

`default_nettype wire

// ----- tb/sv/tb_mru_recency_list.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mru_recency_list
// Self-checking bench for the move-to-front key list. A behavioral copy of
// the list predicts each response as requests are accepted. A monitor
// compares every response field against the oldest prediction. Directed tests
// cover the empty list, key extremes, hits, index errors, the unused command
// and eviction at a clamped limit. Random phases then run under a range of
// limit settings, with and without sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mru_recency_list;
  import mru_pkg::*;

  localparam int        CLK_HALF    = 5;
  localparam int        MAX_CYCLES  = 200000;
  localparam int        NUM_SLOTS   = 16;
  localparam int        POOL_SIZE   = 24;
  localparam int        PHASE_ITEMS = 42;
  localparam int        GAP_PCT     = 19;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // DUT ports
  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  rsp_t             rsp_o;
  logic             rsp_valid_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data_i;

  // Behavioral list state
  logic [KEY_W-1:0] list_keys [NUM_SLOTS];
  int               list_count = 0;
  int               list_limit = 16;

  // Expected responses, oldest first
  rsp_t             pending_rsp [$];

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  bit               gaps_on = 1'b1;
  int               errors = 0;
  int               cycle_count = 0;
  int               n_requests = 0;
  int               n_hits = 0;
  int               n_evicts = 0;
  int               n_index_err = 0;
  int               n_limit_writes = 0;

  mru_recency_list u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .rsp_valid_o (rsp_valid_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("%0t: run did not finish within %0d cycles", $time, MAX_CYCLES);
      $display("FAILURE");
      $finish;
    end
  end

  // Delete one entry and close the gap
  function automatic void list_drop(input int pos);
    int i;
    for (i = pos; i + 1 < list_count; i++) list_keys[i] = list_keys[i + 1];
    list_count--;
  endfunction

  // Apply one request to the list and return the response it should produce
  function automatic rsp_t predict_rsp(input req_t rq);
    rsp_t r;
    int   pos;
    int   i;
    r   = '0;
    pos = -1;
    case (rq.command)
      CMD_ADD: begin
        for (i = 0; i < list_count; i++)
          if (pos < 0 && list_keys[i] == rq.key) pos = i;
        if (pos >= 0) begin
          list_drop(pos);
          r.hit          = 1'b1;
          r.hit_position = pos[IDX_W-1:0];
          n_hits++;
        end else if (list_count >= list_limit && list_count > 0) begin
          r.evicted     = 1'b1;
          r.evicted_key = list_keys[list_count - 1];
          list_count--;
          n_evicts++;
        end
        // push to front
        for (i = list_count; i > 0; i--) list_keys[i] = list_keys[i - 1];
        list_keys[0] = rq.key;
        list_count++;
      end
      CMD_READ, CMD_REMOVE: begin
        if (int'(rq.index) >= list_count) begin
          r.index_error = 1'b1;
          n_index_err++;
        end else if (rq.command == CMD_READ) begin
          r.entry_key = list_keys[rq.index];
        end else begin
          list_drop(int'(rq.index));
        end
      end
      default: ;
    endcase
    r.entry_count = list_count[CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [KEY_W-1:0] exp_v,
                                      input logic [KEY_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  // Response checker
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp_valid_o) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected response: expected none, actual %p", $time, rsp_o);
        errors++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        check_field("entry_key",    exp_rsp.entry_key,    rsp_o.entry_key);
        check_field("hit",          KEY_W'(exp_rsp.hit),  KEY_W'(rsp_o.hit));
        check_field("hit_position", KEY_W'(exp_rsp.hit_position),
                    KEY_W'(rsp_o.hit_position));
        check_field("evicted",      KEY_W'(exp_rsp.evicted), KEY_W'(rsp_o.evicted));
        check_field("evicted_key",  exp_rsp.evicted_key,  rsp_o.evicted_key);
        check_field("index_error",  KEY_W'(exp_rsp.index_error),
                    KEY_W'(rsp_o.index_error));
        check_field("entry_count",  KEY_W'(exp_rsp.entry_count),
                    KEY_W'(rsp_o.entry_count));
      end
    end
  end

  // Send one request, with an optional random gap in front of it
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] idx);
    req_t rq;
    int   gap;
    rq.command = cmd;
    rq.key     = key;
    rq.index   = idx;
    gap        = 0;
    if (gaps_on && $urandom_range(0, 99) < GAP_PCT) gap = $urandom_range(1, 4);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    pending_rsp.insert(pending_rsp.size(), predict_rsp(rq));
    n_requests++;
  endtask

  // Stop sending and wait for every outstanding response
  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Write the limit register; the list must be idle
  task automatic write_limit(input logic [CNT_W-1:0] value);
    int lim;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    lim = int'(value);
    if (lim < int'(LIMIT_LOW)) lim = int'(LIMIT_LOW);
    else if (lim > int'(LIMIT_HIGH)) lim = int'(LIMIT_HIGH);
    list_limit = lim;
    if (list_count > list_limit) list_count = list_limit;
    n_limit_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reads, removes and the unused command on an empty list
  task automatic test_empty_list();
    send_request(CMD_READ,   '0, 4'd0);
    send_request(CMD_REMOVE, '0, 4'd15);
    send_request(CMD_UNUSED, '1, 4'd15);
  endtask

  // Key extremes, a hit, reads in and out of range, removes down to empty
  task automatic test_add_hit_read_remove();
    send_request(CMD_ADD,    64'h0, 4'd0);
    send_request(CMD_ADD,    '1, 4'd15);
    send_request(CMD_ADD,    64'h0, 4'd7);
    send_request(CMD_READ,   '0, 4'd0);
    send_request(CMD_READ,   '0, 4'd1);
    send_request(CMD_READ,   '1, 4'd2);
    send_request(CMD_ADD,    64'h8000_0000_0000_0001, 4'd0);
    send_request(CMD_READ,   '0, 4'd15);
    send_request(CMD_REMOVE, '0, 4'd1);
    send_request(CMD_REMOVE, '0, 4'd1);
    send_request(CMD_REMOVE, '0, 4'd0);
    send_request(CMD_UNUSED, 64'h5555_aaaa_5555_aaaa, 4'd10);
  endtask

  // Limit below range clamps to four; overflow evicts the oldest
  task automatic test_limit_clamp_evict();
    int i;
    wait_idle();
    write_limit(5'd0);
    for (i = 0; i < 6; i++)
      send_request(CMD_ADD, 64'hA5A5_0000_0000_0000 | i, 4'(i));
    send_request(CMD_ADD,  64'hA5A5_0000_0000_0002, 4'd0);  // oldest, hit at 3
    send_request(CMD_READ, '0, 4'd3);
    wait_idle();
    write_limit(5'd31);
    send_request(CMD_ADD, 64'hA5A5_0000_0000_0006, 4'd0);
  endtask

  // Random mix of operations over a small key pool so hits and evictions recur
  task automatic test_random_phases();
    logic [CNT_W-1:0] phase_limits [9];
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    int               p;
    int               n;
    int               sel;
    phase_limits = '{5'd17, 5'd16, 5'd3, 5'd16, 5'd9, 5'd1, 5'd31, 5'd12, 5'd4};
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (p = 0; p < 9; p++) begin
      // hold off until every response is in, then change the limit
      wait_idle();
      write_limit(phase_limits[p]);
      gaps_on = (p != 3);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(0, 99);
        key = {$urandom, $urandom};
        idx = 4'($urandom_range(0, 15));
        if (sel < 55) begin
          cmd = CMD_ADD;
          if ($urandom_range(0, 9) < 7) key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (sel < 95) begin
          cmd = (sel < 80) ? CMD_READ : CMD_REMOVE;
          if (list_count > 0 && $urandom_range(0, 3) != 0)
            idx = 4'($urandom_range(0, list_count - 1));
        end else begin
          cmd = CMD_UNUSED;
        end
        send_request(cmd, key, idx);
      end
    end
    gaps_on = 1'b1;
  endtask

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    foreach (list_keys[i]) list_keys[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_list();
    test_add_hit_read_remove();
    test_limit_clamp_evict();
    test_random_phases();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (pending_rsp.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_rsp.size());
      errors++;
    end

    $display("Covered %0d requests and %0d limit writes, %0d hits, %0d evictions,",
             n_requests, n_limit_writes, n_hits, n_evicts);
    $display("%0d out-of-range indexes; %0d mismatches.", n_index_err, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
